### sv/ndd_pkg.sv
// Shared constants, types and helpers of the divided-difference interpolator.
package ndd_pkg;

  localparam int MAX_POINTS = 16;
  localparam int FRAC_BITS  = 16;
  localparam int WORK_DEPTH = 16;
  localparam int DW         = 32;
  localparam int AW         = $clog2(MAX_POINTS);
  localparam int CNT_W      = $clog2(MAX_POINTS + 1);
  localparam int WAW        = $clog2(WORK_DEPTH);
  localparam int IDX_W      = $clog2(WORK_DEPTH + 1);
  localparam int NUM_W      = DW + FRAC_BITS;
  localparam int DIV_CW     = $clog2(NUM_W + 1);

  localparam logic signed [DW-1:0] FX_ONE = DW'(64'd1 << FRAC_BITS);

  typedef enum logic [1:0] {
    CMD_APPEND = 2'd0,
    CMD_EVAL   = 2'd1,
    CMD_CLEAR  = 2'd2
  } cmd_e;

  typedef enum logic [2:0] {
    ST_OK    = 3'd0,
    ST_RANGE = 3'd1,
    ST_FEW   = 3'd2,
    ST_FULL  = 3'd3,
    ST_DUP   = 3'd4
  } status_e;

  typedef enum logic [4:0] {
    S_IDLE, S_RNG_RD, S_RNG_CHK, S_CPY_RD, S_CPY_WR, S_LVL_RD, S_LVL_LO,
    S_STP_RD, S_STP_CHK, S_DIV, S_MUL_RD, S_MUL_F, S_MUL_P1, S_MUL_M,
    S_MUL_P2, S_MUL_S
  } state_e;

  // clamp a wide signed value to 32 bits
  function automatic logic signed [DW-1:0] sat32(input logic signed [64:0] v);
    logic signed [64:0] hi;
    logic signed [64:0] lo;
    hi = 65'sh0_7FFF_FFFF;
    lo = -65'sh0_8000_0000;
    if (v > hi) return DW'(hi);
    if (v < lo) return DW'(lo);
    return DW'(v);
  endfunction

endpackage

### sv/ndd_div.sv
// Bit-serial restoring divider: sat32((num << FRAC_BITS) / den), truncated toward zero.
module ndd_div (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic signed [ndd_pkg::DW-1:0]  num_i,
  input  logic signed [ndd_pkg::DW:0]    den_i,
  output logic                           done_o,
  output logic signed [ndd_pkg::DW-1:0]  quot_o
);

  localparam int DW     = ndd_pkg::DW;
  localparam int NUM_W  = ndd_pkg::NUM_W;
  localparam int DIV_CW = ndd_pkg::DIV_CW;
  localparam int FB     = ndd_pkg::FRAC_BITS;
  localparam logic [NUM_W-1:0] LIM = NUM_W'(64'h8000_0000);

  logic              busy_q;
  logic [DIV_CW-1:0] cnt_q;
  logic [DW+1:0]     rem_q;
  logic [NUM_W-1:0]  quo_q;
  logic [DW:0]       dvs_q;
  logic              neg_q;
  logic              done_q;
  logic signed [DW-1:0] quot_q;

  logic [DW-1:0]  num_mag;
  logic [DW:0]    den_mag;
  logic [DW+1:0]  rem_sh;
  logic           ge;
  logic signed [DW-1:0] res;

  // operand magnitudes and one restoring step
  always_comb begin
    num_mag = num_i[DW-1] ? DW'(-num_i) : DW'(num_i);
    den_mag = den_i[DW] ? (DW+1)'(-den_i) : (DW+1)'(den_i);
    rem_sh  = {rem_q[DW:0], quo_q[NUM_W-1]};
    ge      = rem_sh >= (DW+2)'(dvs_q);
  end

  // sign and saturate the magnitude quotient
  always_comb begin
    if (neg_q) begin
      if (quo_q > LIM) res = -32'sh8000_0000;
      else res = -$signed(quo_q[DW-1:0]);
    end else begin
      if (quo_q >= LIM) res = 32'sh7FFF_FFFF;
      else res = $signed(quo_q[DW-1:0]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      rem_q  <= '0;
      quo_q  <= '0;
      dvs_q  <= '0;
      neg_q  <= 1'b0;
      done_q <= 1'b0;
      quot_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
        rem_q  <= '0;
        quo_q  <= {num_mag, FB'(0)};
        dvs_q  <= den_mag;
        neg_q  <= num_i[DW-1] ^ den_i[DW];
      end else if (busy_q) begin
        if (cnt_q == DIV_CW'(NUM_W)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
          quot_q <= res;
        end else begin
          rem_q <= ge ? (rem_sh - (DW+2)'(dvs_q)) : rem_sh;
          quo_q <= {quo_q[NUM_W-2:0], ge};
          cnt_q <= cnt_q + DIV_CW'(1);
        end
      end
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

### sv/newton_divided_difference_interp.sv
// Newton divided-difference interpolator: point table, difference memory and sequencer.
// Each command (append, clear, evaluate) returns one word on value_o/status_o, marked by
// done_o for one cycle; start is taken while busy is low. Append and clear answer in the
// cycle after start. Evaluate runs a range scan over the stored abscissas (S_RNG_RD and
// S_RNG_CHK per point), copies degree+1 ordinates into the difference memory (S_CPY_RD and
// S_CPY_WR each), then for each level k computes degree+1-k differences with a
// 1-bit-per-cycle divider (48 quotient bits) and folds the new coefficient into the sum
// in the multiply states S_MUL_RD to S_MUL_S. A full degree-15 query takes 120 divisions.
// The receiver cannot stall results, so done_o must be sampled when it pulses.
module newton_divided_difference_interp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    cmd_i,
  input  logic signed [ndd_pkg::DW-1:0] point_x_i,
  input  logic signed [ndd_pkg::DW-1:0] point_y_i,
  input  logic signed [ndd_pkg::DW-1:0] query_x_i,
  input  logic [3:0]                    degree_i,
  output logic signed [ndd_pkg::DW-1:0] value_o,
  output logic [2:0]                    status_o,
  output logic                          done_o
);

  localparam int DW    = ndd_pkg::DW;
  localparam int AW    = ndd_pkg::AW;
  localparam int CNT_W = ndd_pkg::CNT_W;
  localparam int WAW   = ndd_pkg::WAW;
  localparam int IDX_W = ndd_pkg::IDX_W;
  localparam int FB    = ndd_pkg::FRAC_BITS;

  function automatic logic [AW-1:0] xaddr(input logic [IDX_W-1:0] v);
    return AW'(v);
  endfunction

  // point and difference memories
  logic signed [DW-1:0] x_mem [ndd_pkg::MAX_POINTS];
  logic signed [DW-1:0] y_mem [ndd_pkg::MAX_POINTS];
  logic signed [DW-1:0] w_mem [ndd_pkg::WORK_DEPTH];

  logic                 pt_we;
  logic [AW-1:0]        xa_addr, xb_addr, y_addr;
  logic signed [DW-1:0] xa_rd_q, xb_rd_q, y_rd_q, w_rd_q;
  logic                 w_we;
  logic [WAW-1:0]       w_waddr, w_raddr;
  logic signed [DW-1:0] w_wdata;

  // control and datapath registers
  ndd_pkg::state_e      state_q, state_d;
  ndd_pkg::status_e     status_q, status_d;
  logic [CNT_W-1:0]     count_q, count_d, i_q, i_d;
  logic [IDX_W-1:0]     n_q, n_d, j_q, j_d, k_q, k_d;
  logic signed [DW-1:0] qx_q, qx_d, prev_q, prev_d, lo_q, lo_d;
  logic signed [DW-1:0] sum_q, sum_d, mult_q, mult_d, coef_q, coef_d, fac_q, fac_d;
  logic signed [DW-1:0] value_q, value_d;
  logic signed [2*DW-1:0] prod_q, prod_d;
  logic                 done_q, done_d;

  // shared multiplier operands
  logic signed [DW-1:0] mul_a, mul_b;

  // divider hookup
  logic                 div_start, div_done;
  logic signed [DW-1:0] div_num, div_quot;
  logic signed [DW:0]   div_den;

  logic [IDX_W-1:0]     j_nx;
  logic signed [DW-1:0] sum_nx;

  ndd_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  // memories: one write per cycle, registered reads
  always_ff @(posedge clk_i) begin
    if (pt_we) begin
      x_mem[count_q[AW-1:0]] <= point_x_i;
      y_mem[count_q[AW-1:0]] <= point_y_i;
    end
    xa_rd_q <= x_mem[xa_addr];
    xb_rd_q <= x_mem[xb_addr];
    y_rd_q  <= y_mem[y_addr];
  end

  always_ff @(posedge clk_i) begin
    if (w_we) w_mem[w_waddr] <= w_wdata;
    w_rd_q <= w_mem[w_raddr];
  end

  // sequencer: next state and datapath updates
  always_comb begin
    state_d  = state_q;
    status_d = status_q;
    count_d  = count_q;
    i_d      = i_q;
    n_d      = n_q;
    j_d      = j_q;
    k_d      = k_q;
    qx_d     = qx_q;
    prev_d   = prev_q;
    lo_d     = lo_q;
    sum_d    = sum_q;
    mult_d   = mult_q;
    coef_d   = coef_q;
    fac_d    = fac_q;
    value_d  = value_q;
    prod_d   = prod_q;
    done_d   = 1'b0;
    pt_we    = 1'b0;
    xa_addr  = '0;
    xb_addr  = '0;
    y_addr   = '0;
    w_we     = 1'b0;
    w_waddr  = '0;
    w_raddr  = '0;
    w_wdata  = y_rd_q;
    mul_a    = mult_q;
    mul_b    = fac_q;
    div_start = 1'b0;
    div_num  = ndd_pkg::sat32(65'(w_rd_q) - 65'(lo_q));
    div_den  = (DW+1)'(xb_rd_q) - (DW+1)'(xa_rd_q);
    j_nx     = j_q + IDX_W'(1);
    sum_nx   = ndd_pkg::sat32(65'(sum_q)
               + 65'(ndd_pkg::sat32(65'(prod_q >>> FB))));

    unique case (state_q)
      ndd_pkg::S_IDLE: begin
        if (start) begin
          value_d = '0;
          unique case (cmd_i)
            ndd_pkg::CMD_APPEND: begin
              done_d = 1'b1;
              if (count_q == CNT_W'(ndd_pkg::MAX_POINTS)) begin
                status_d = ndd_pkg::ST_FULL;
              end else begin
                pt_we    = 1'b1;
                count_d  = count_q + CNT_W'(1);
                status_d = ndd_pkg::ST_OK;
              end
            end
            ndd_pkg::CMD_EVAL: begin
              qx_d = query_x_i;
              n_d  = IDX_W'(degree_i) + IDX_W'(1);
              i_d  = '0;
              if (count_q < CNT_W'(2)) begin
                done_d   = 1'b1;
                status_d = ndd_pkg::ST_RANGE;
              end else begin
                state_d = ndd_pkg::S_RNG_RD;
              end
            end
            ndd_pkg::CMD_CLEAR: begin
              done_d   = 1'b1;
              count_d  = '0;
              status_d = ndd_pkg::ST_OK;
            end
            default: begin
              done_d   = 1'b1;
              status_d = ndd_pkg::ST_OK;
            end
          endcase
        end
      end

      // range scan: compare query against each adjacent pair
      ndd_pkg::S_RNG_RD: begin
        xa_addr = i_q[AW-1:0];
        state_d = ndd_pkg::S_RNG_CHK;
      end
      ndd_pkg::S_RNG_CHK: begin
        prev_d = xa_rd_q;
        if (i_q != '0 && prev_q < qx_q && qx_q < xa_rd_q) begin
          j_d = '0;
          if (int'(n_q) > int'(count_q)) begin
            done_d   = 1'b1;
            status_d = ndd_pkg::ST_FEW;
            state_d  = ndd_pkg::S_IDLE;
          end else begin
            state_d = ndd_pkg::S_CPY_RD;
          end
        end else if (i_q == count_q - CNT_W'(1)) begin
          done_d   = 1'b1;
          status_d = ndd_pkg::ST_RANGE;
          state_d  = ndd_pkg::S_IDLE;
        end else begin
          i_d     = i_q + CNT_W'(1);
          state_d = ndd_pkg::S_RNG_RD;
        end
      end

      // copy ordinates into the difference memory
      ndd_pkg::S_CPY_RD: begin
        y_addr  = xaddr(j_q);
        state_d = ndd_pkg::S_CPY_WR;
      end
      ndd_pkg::S_CPY_WR: begin
        w_we    = 1'b1;
        w_waddr = j_q[WAW-1:0];
        w_wdata = y_rd_q;
        if (j_q == '0) sum_d = y_rd_q;
        j_d = j_nx;
        if (j_nx == n_q) begin
          if (n_q == IDX_W'(1)) begin
            done_d   = 1'b1;
            value_d  = y_rd_q;
            status_d = ndd_pkg::ST_OK;
            state_d  = ndd_pkg::S_IDLE;
          end else begin
            k_d     = IDX_W'(1);
            mult_d  = ndd_pkg::FX_ONE;
            state_d = ndd_pkg::S_LVL_RD;
          end
        end else begin
          state_d = ndd_pkg::S_CPY_RD;
        end
      end

      // one level of the difference table
      ndd_pkg::S_LVL_RD: begin
        w_raddr = '0;
        j_d     = '0;
        state_d = ndd_pkg::S_LVL_LO;
      end
      ndd_pkg::S_LVL_LO: begin
        lo_d    = w_rd_q;
        state_d = ndd_pkg::S_STP_RD;
      end
      ndd_pkg::S_STP_RD: begin
        w_raddr = j_nx[WAW-1:0];
        xa_addr = xaddr(j_q);
        xb_addr = xaddr(j_q + k_q);
        state_d = ndd_pkg::S_STP_CHK;
      end
      ndd_pkg::S_STP_CHK: begin
        if (div_den == '0) begin
          done_d   = 1'b1;
          value_d  = '0;
          status_d = ndd_pkg::ST_DUP;
          state_d  = ndd_pkg::S_IDLE;
        end else begin
          div_start = 1'b1;
          lo_d      = w_rd_q;
          state_d   = ndd_pkg::S_DIV;
        end
      end
      ndd_pkg::S_DIV: begin
        if (div_done) begin
          w_we    = 1'b1;
          w_waddr = j_q[WAW-1:0];
          w_wdata = div_quot;
          if (j_q == '0) coef_d = div_quot;
          j_d = j_nx;
          if (j_nx + k_q == n_q) state_d = ndd_pkg::S_MUL_RD;
          else state_d = ndd_pkg::S_STP_RD;
        end
      end

      // fold coefficient k into the Newton sum
      ndd_pkg::S_MUL_RD: begin
        xa_addr = xaddr(k_q - IDX_W'(1));
        state_d = ndd_pkg::S_MUL_F;
      end
      ndd_pkg::S_MUL_F: begin
        fac_d   = ndd_pkg::sat32(65'(qx_q) - 65'(xa_rd_q));
        state_d = ndd_pkg::S_MUL_P1;
      end
      ndd_pkg::S_MUL_P1: begin
        mul_a   = mult_q;
        mul_b   = fac_q;
        prod_d  = (2*DW)'(mul_a) * (2*DW)'(mul_b);
        state_d = ndd_pkg::S_MUL_M;
      end
      ndd_pkg::S_MUL_M: begin
        mult_d  = ndd_pkg::sat32(65'(prod_q >>> FB));
        state_d = ndd_pkg::S_MUL_P2;
      end
      ndd_pkg::S_MUL_P2: begin
        mul_a   = coef_q;
        mul_b   = mult_q;
        prod_d  = (2*DW)'(mul_a) * (2*DW)'(mul_b);
        state_d = ndd_pkg::S_MUL_S;
      end
      ndd_pkg::S_MUL_S: begin
        sum_d = sum_nx;
        k_d   = k_q + IDX_W'(1);
        if (k_q + IDX_W'(1) == n_q) begin
          done_d   = 1'b1;
          value_d  = sum_nx;
          status_d = ndd_pkg::ST_OK;
          state_d  = ndd_pkg::S_IDLE;
        end else begin
          state_d = ndd_pkg::S_LVL_RD;
        end
      end

      default: state_d = ndd_pkg::S_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ndd_pkg::S_IDLE;
      count_q  <= '0;
      done_q   <= 1'b0;
      status_q <= ndd_pkg::ST_OK;
      value_q  <= '0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      done_q   <= done_d;
      status_q <= status_d;
      value_q  <= value_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    i_q    <= i_d;
    n_q    <= n_d;
    j_q    <= j_d;
    k_q    <= k_d;
    qx_q   <= qx_d;
    prev_q <= prev_d;
    lo_q   <= lo_d;
    sum_q  <= sum_d;
    mult_q <= mult_d;
    coef_q <= coef_d;
    fac_q  <= fac_d;
    prod_q <= prod_d;
  end

  assign busy     = state_q != ndd_pkg::S_IDLE;
  assign value_o  = value_q;
  assign status_o = status_q;
  assign done_o   = done_q;

endmodule
